/* rtl/core/coin_change_selector_unit_macros.svh */
// Assertion macros shared by the RTL of the coin change selector.
// Every macro samples on the rising edge of clk_i and is disabled while rst_ni is low.
`ifndef COIN_CHANGE_SELECTOR_UNIT_MACROS_SVH
`define COIN_CHANGE_SELECTOR_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CSEL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define CSEL_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`else

`define CSEL_ASSERT(lbl, prop, msg)

`define CSEL_ASSERT_IMPL(lbl, pre, post, msg)

`endif

`endif

/* rtl/core/csel_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package csel_pkg;

  localparam int MAX_COINS     = 11;
  localparam int INITIAL_STOCK = 10;
  localparam int TARGET_RESET  = 10;

  localparam int COIN_200 = 200;
  localparam int COIN_50  = 50;

  localparam int AMT_W   = 16;
  localparam int STOCK_W = 8;
  localparam int PAY_W   = 4;
  localparam int DEV_W   = 10;
  localparam int RES_W   = 8;   // amount modulo 200
  localparam int Q_W     = 9;   // amount divided by 200

  // Division of the amount by 200: shift out the factor 8, then multiply by a
  // rounded-up reciprocal of 25. Exact for every 13-bit dividend.
  localparam int DIV_SHIFT   = 3;
  localparam int DIVD_W      = AMT_W - DIV_SHIFT;
  localparam int RECIP_MULT  = 5243;
  localparam int RECIP_SHIFT = 17;
  localparam int PROD_W      = 2 * DIVD_W;

  localparam int CNT_W = $clog2(MAX_COINS + 1);
  localparam int INC_W = CNT_W + 1;
  localparam int U_W   = CNT_W + 2;
  localparam int CMP_W = STOCK_W + 1;
  localparam int SUM_W = Q_W + 1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_200 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_100 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_50  = 2'd2;

  typedef struct packed {
    logic load;
    logic div;
    logic rem;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic last;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/core/csel_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "coin_change_selector_unit_macros.svh"

module csel_dp import csel_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [STOCK_W-1:0]   cfg_data_i,
  input  logic [AMT_W-1:0]     amount_cents_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic                 found_o,
  output logic [PAY_W-1:0]     pay_200_o,
  output logic [PAY_W-1:0]     pay_100_o,
  output logic [PAY_W-1:0]     pay_50_o,
  output logic [DEV_W-1:0]     deviation_o
);

  function automatic logic [STOCK_W-1:0] abs_diff(input logic [STOCK_W-1:0] x,
                                                  input logic [STOCK_W-1:0] y);
    return (x > y) ? (x - y) : (y - x);
  endfunction

  // Control state with reset values.
  logic [STOCK_W-1:0] stock_200_q, stock_100_q, stock_50_q;
  logic [STOCK_W-1:0] tgt_200_q, tgt_100_q, tgt_50_q;
  logic               s1_vld_q;
  logic               best_have_q;

  // Working registers.
  logic [AMT_W-1:0]   amount_q;
  logic [Q_W-1:0]     q_q;
  logic [RES_W-1:0]   rem_q;
  logic [CNT_W-1:0]   b_q, c_q;
  logic [CNT_W-1:0]   s1_a_q, s1_b_q, s1_c_q;
  logic [DEV_W-1:0]   best_dev_q;
  logic [CNT_W-1:0]   best_a_q, best_b_q, best_c_q;
  logic               found_q;
  logic [PAY_W-1:0]   pay_200_q, pay_100_q, pay_50_q;
  logic [DEV_W-1:0]   dev_q;

  // Quotient and remainder of the amount by 200.
  logic [PROD_W-1:0]  div_prod;
  logic [Q_W-1:0]     q_d;
  logic [RES_W-1:0]   rem_d;

  assign div_prod = PROD_W'(amount_q[AMT_W-1:DIV_SHIFT]) * PROD_W'(RECIP_MULT);
  assign q_d      = div_prod[RECIP_SHIFT +: Q_W];
  assign rem_d    = RES_W'(amount_q - AMT_W'(q_q) * AMT_W'(COIN_200));

  // Candidate evaluation. The candidate uses b hundreds and c fifties; its
  // value is (2b + c) fifties, so it matches the remainder modulo 200 only
  // when 50 * ((2b + c) mod 4) equals it, and the twos are then q - (2b+c)/4.
  logic [U_W-1:0]     units;
  logic [AMT_W-1:0]   part;
  logic               over;
  logic               res_match;
  logic [Q_W-1:0]     a_full;
  logic [SUM_W-1:0]   coin_sum;
  logic               cand_ok;
  logic [INC_W-1:0]   b_inc, c_inc;
  logic               more_b, more_c;

  assign units     = U_W'({b_q, 1'b0}) + U_W'(c_q);
  assign part      = AMT_W'(units) * AMT_W'(COIN_50);
  assign over      = part > amount_q;
  assign res_match = rem_q == RES_W'(units[1:0]) * RES_W'(COIN_50);
  assign a_full    = q_q - Q_W'(units >> 2);
  assign coin_sum  = SUM_W'(a_full) + SUM_W'(b_q) + SUM_W'(c_q);
  assign cand_ok   = !over && res_match && (a_full <= Q_W'(stock_200_q))
                     && (coin_sum <= SUM_W'(MAX_COINS));

  assign b_inc  = INC_W'(b_q) + INC_W'(1);
  assign c_inc  = INC_W'(c_q) + INC_W'(1);
  assign more_b = !over && (CMP_W'(b_inc) <= CMP_W'(stock_100_q))
                  && (U_W'(b_inc) + U_W'(c_q) <= U_W'(MAX_COINS));
  assign more_c = (CMP_W'(c_inc) <= CMP_W'(stock_50_q)) && (c_inc <= INC_W'(MAX_COINS));

  assign sts_o.last = !more_b && !more_c;

  // Second stage: deviation of the stock left over and the running best.
  logic [STOCK_W-1:0] left_200, left_100, left_50;
  logic [DEV_W-1:0]   dev;
  logic               take;

  assign left_200 = stock_200_q - STOCK_W'(s1_a_q);
  assign left_100 = stock_100_q - STOCK_W'(s1_b_q);
  assign left_50  = stock_50_q - STOCK_W'(s1_c_q);
  assign dev      = DEV_W'(abs_diff(left_200, tgt_200_q)) + DEV_W'(abs_diff(left_100, tgt_100_q))
                    + DEV_W'(abs_diff(left_50, tgt_50_q));
  // Later candidates win ties.
  assign take     = s1_vld_q && (!best_have_q || (dev <= best_dev_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stock_200_q <= STOCK_W'(INITIAL_STOCK);
      stock_100_q <= STOCK_W'(INITIAL_STOCK);
      stock_50_q  <= STOCK_W'(INITIAL_STOCK);
      tgt_200_q   <= STOCK_W'(TARGET_RESET);
      tgt_100_q   <= STOCK_W'(TARGET_RESET);
      tgt_50_q    <= STOCK_W'(TARGET_RESET);
      s1_vld_q    <= 1'b0;
      best_have_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_TGT_200: tgt_200_q <= cfg_data_i;
          CFG_TGT_100: tgt_100_q <= cfg_data_i;
          CFG_TGT_50:  tgt_50_q  <= cfg_data_i;
          default: ;
        endcase
      end
      s1_vld_q <= cmd_i.step && cand_ok;
      if (cmd_i.rem) begin
        best_have_q <= 1'b0;
      end else if (take) begin
        best_have_q <= 1'b1;
      end
      if (cmd_i.commit && best_have_q) begin
        stock_200_q <= stock_200_q - STOCK_W'(best_a_q);
        stock_100_q <= stock_100_q - STOCK_W'(best_b_q);
        stock_50_q  <= stock_50_q - STOCK_W'(best_c_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      amount_q <= amount_cents_i;
    end
    if (cmd_i.div) begin
      q_q <= q_d;
    end
    if (cmd_i.rem) begin
      rem_q <= rem_d;
      b_q   <= '0;
      c_q   <= '0;
    end else if (cmd_i.step) begin
      if (more_b) begin
        b_q <= CNT_W'(b_inc);
      end else if (more_c) begin
        b_q <= '0;
        c_q <= CNT_W'(c_inc);
      end
    end
    if (cmd_i.step) begin
      s1_a_q <= CNT_W'(a_full);
      s1_b_q <= b_q;
      s1_c_q <= c_q;
    end
    if (take) begin
      best_dev_q <= dev;
      best_a_q   <= s1_a_q;
      best_b_q   <= s1_b_q;
      best_c_q   <= s1_c_q;
    end
    if (cmd_i.commit) begin
      found_q   <= best_have_q;
      pay_200_q <= best_have_q ? PAY_W'(best_a_q) : '0;
      pay_100_q <= best_have_q ? PAY_W'(best_b_q) : '0;
      pay_50_q  <= best_have_q ? PAY_W'(best_c_q) : '0;
      dev_q     <= best_have_q ? best_dev_q : '0;
    end
  end

  assign found_o     = found_q;
  assign pay_200_o   = pay_200_q;
  assign pay_100_o   = pay_100_q;
  assign pay_50_o    = pay_50_q;
  assign deviation_o = dev_q;

  `CSEL_ASSERT_IMPL(a_cand_coin_limit, s1_vld_q, SUM_W'(s1_a_q) + SUM_W'(s1_b_q) + SUM_W'(s1_c_q) <= SUM_W'(MAX_COINS), "candidate exceeds coin limit")
  `CSEL_ASSERT_IMPL(a_cand_in_stock, s1_vld_q, (STOCK_W'(s1_a_q) <= stock_200_q) && (STOCK_W'(s1_b_q) <= stock_100_q) && (STOCK_W'(s1_c_q) <= stock_50_q), "candidate exceeds stock")
  `CSEL_ASSERT(a_commit_result, (cmd_i.commit && best_have_q) |=> (found_q && (dev_q == $past(best_dev_q))), "committed result lost")

endmodule

`default_nettype wire

/* rtl/core/csel_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "coin_change_selector_unit_macros.svh"

module csel_ctrl import csel_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_REM,
    S_SCAN,
    S_DRAIN,
    S_FIN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;

  assign in_ready_o = state_q == S_IDLE;
  assign slot_free  = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.div    = state_q == S_DIV;
    cmd_o.rem    = state_q == S_REM;
    cmd_o.step   = state_q == S_SCAN;
    cmd_o.commit = (state_q == S_FIN) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // A new result may replace the one taken in this same cycle.
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_DIV;
          end
        end
        S_DIV:  state_q <= S_REM;
        S_REM:  state_q <= S_SCAN;
        S_SCAN: begin
          if (sts_i.last) begin
            state_q <= S_DRAIN;
          end
        end
        // The last candidate still sits in the compare stage.
        S_DRAIN: state_q <= S_FIN;
        S_FIN: begin
          if (slot_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  `CSEL_ASSERT_IMPL(a_commit_slot_free, cmd_o.commit, !out_valid_q || out_ready_i, "result register overwritten")
  `CSEL_ASSERT(a_commit_shows_beat, cmd_o.commit |=> out_valid_q, "committed result not shown")
  `CSEL_ASSERT(a_last_drains, (cmd_o.step && sts_i.last) |=> (state_q == S_DRAIN), "scan end missed")

endmodule

`default_nettype wire

/* rtl/core/coin_change_selector_unit.sv */
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    amount_cents_i
// out      output     out_valid_o / out_ready_i  found_o, pay_200_o, pay_100_o, pay_50_o,
//                                                deviation_o
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One item at a time. After a beat is taken, S_DIV forms the quotient of the amount
// by 200 and S_REM the remainder; then one candidate (count of 100 and 50 cent coins)
// is checked per cycle through the shared evaluate and compare stages, up to 76 for
// the reset stock and the default coin limit. S_DRAIN lets the last one through the
// compare stage, then S_FIN commits the result and the block returns to idle.
// A new beat is taken while the previous result still waits on out; a result that
// finds the output register full waits until it is taken. cfg is always ready.
// Reset sets stock and target levels to ten coins each.
`timescale 1ns / 1ps
`default_nettype none

module coin_change_selector_unit import csel_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [AMT_W-1:0]     amount_cents_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 found_o,
  output logic [PAY_W-1:0]     pay_200_o,
  output logic [PAY_W-1:0]     pay_100_o,
  output logic [PAY_W-1:0]     pay_50_o,
  output logic [DEV_W-1:0]     deviation_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [STOCK_W-1:0]   cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  csel_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  csel_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .amount_cents_i (amount_cents_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .found_o        (found_o),
    .pay_200_o      (pay_200_o),
    .pay_100_o      (pay_100_o),
    .pay_50_o       (pay_50_o),
    .deviation_o    (deviation_o)
  );

endmodule

`default_nettype wire

/* sim/coin_change_selector_unit_tb.sv */
`timescale 1ns / 1ps

module coin_change_selector_unit_tb;
  import csel_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 200;
  localparam int LONG_HOLD_CYCLES = 1500;
  localparam int PHASE_ITEMS = 150;

  typedef struct packed {
    logic             found;
    logic [PAY_W-1:0] n200;
    logic [PAY_W-1:0] n100;
    logic [PAY_W-1:0] n50;
    logic [DEV_W-1:0] dev;
  } payout_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [AMT_W-1:0]     amount_cents_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 found_o;
  logic [PAY_W-1:0]     pay_200_o;
  logic [PAY_W-1:0]     pay_100_o;
  logic [PAY_W-1:0]     pay_50_o;
  logic [DEV_W-1:0]     deviation_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [STOCK_W-1:0]   cfg_data_i = '0;

  // Predictor state: coins on hand and target levels, as the block holds them.
  logic [STOCK_W-1:0] left_200 = STOCK_W'(INITIAL_STOCK);
  logic [STOCK_W-1:0] left_100 = STOCK_W'(INITIAL_STOCK);
  logic [STOCK_W-1:0] left_50 = STOCK_W'(INITIAL_STOCK);
  logic [STOCK_W-1:0] level_200 = STOCK_W'(TARGET_RESET);
  logic [STOCK_W-1:0] level_100 = STOCK_W'(TARGET_RESET);
  logic [STOCK_W-1:0] level_50 = STOCK_W'(TARGET_RESET);

  logic [AMT_W-1:0] pending_amounts[$];
  payout_t          payouts_due[$];
  int               results_seen = 0;
  int               mismatch_count = 0;
  logic             in_fire = 1'b0;
  bit               calm = 1'b0;

  coin_change_selector_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .amount_cents_i (amount_cents_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .found_o        (found_o),
    .pay_200_o      (pay_200_o),
    .pay_100_o      (pay_100_o),
    .pay_50_o       (pay_50_o),
    .deviation_o    (deviation_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int gap_to(input int have, input int want);
    return (have > want) ? have - want : want - have;
  endfunction

  // Searches every mix of 100 and 50 cent coins, fills the rest with 200s, and keeps
  // the mix closest to the target levels. A later candidate wins a tie.
  function automatic payout_t choose_payout(input logic [AMT_W-1:0] amount);
    payout_t pick;
    bit      have;
    int      c, b, a, part, rest, dev, best_dev, best_a, best_b, best_c;
    have = 1'b0;
    best_dev = 0;
    best_a = 0;
    best_b = 0;
    best_c = 0;
    for (c = 0; c <= int'(left_50) && c <= MAX_COINS; c++) begin
      for (b = 0; b <= int'(left_100) && b + c <= MAX_COINS; b++) begin
        part = 100 * b + COIN_50 * c;
        if (part > int'(amount)) break;
        rest = int'(amount) - part;
        if (rest % COIN_200 != 0) continue;
        a = rest / COIN_200;
        if (a > int'(left_200) || a + b + c > MAX_COINS) continue;
        dev = gap_to(int'(left_200) - a, int'(level_200))
            + gap_to(int'(left_100) - b, int'(level_100))
            + gap_to(int'(left_50) - c, int'(level_50));
        if (!have || dev <= best_dev) begin
          have = 1'b1;
          best_dev = dev;
          best_a = a;
          best_b = b;
          best_c = c;
        end
      end
    end
    pick = '0;
    if (have) begin
      left_200 = left_200 - STOCK_W'(best_a);
      left_100 = left_100 - STOCK_W'(best_b);
      left_50 = left_50 - STOCK_W'(best_c);
      pick.found = 1'b1;
      pick.n200 = PAY_W'(best_a);
      pick.n100 = PAY_W'(best_b);
      pick.n50 = PAY_W'(best_c);
      pick.dev = DEV_W'(best_dev);
    end
    return pick;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid_i && in_ready_o;
    end
  end

  // Monitor: predicts on every accepted amount, checks every accepted result.
  always @(posedge clk_i) begin
    payout_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_TGT_200: level_200 = cfg_data_i;
          CFG_TGT_100: level_100 = cfg_data_i;
          CFG_TGT_50:  level_50 = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        payouts_due.push_back(choose_payout(amount_cents_i));
      end
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (payouts_due.size() == 0) begin
          $error("result beat with no prediction waiting");
          mismatch_count++;
        end else begin
          want = payouts_due.pop_front();
          check_field("found", int'(want.found), int'(found_o));
          check_field("pay_200", int'(want.n200), int'(pay_200_o));
          check_field("pay_100", int'(want.n100), int'(pay_100_o));
          check_field("pay_50", int'(want.n50), int'(pay_50_o));
          check_field("deviation", int'(want.dev), int'(deviation_o));
        end
      end
    end
  end

  // Driver for the amount channel.
  always @(negedge clk_i) begin
    int in_gap;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap = 0;
    end else if (!in_valid_i || in_fire) begin
      if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap--;
      end else if (pending_amounts.size() > 0) begin
        in_valid_i <= 1'b1;
        amount_cents_i <= pending_amounts.pop_front();
        if (!calm && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 12);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side: random stalls, plus one long hold that backs the block up.
  always @(negedge clk_i) begin
    int  out_gap;
    int  long_hold;
    bit  long_hold_done;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_gap = 0;
      long_hold = 0;
      long_hold_done = 1'b0;
    end else if (long_hold > 0) begin
      out_ready_i <= 1'b0;
      long_hold--;
    end else if (!long_hold_done && results_seen >= 200 && pending_amounts.size() > 20) begin
      out_ready_i <= 1'b0;
      long_hold = LONG_HOLD_CYCLES;
      long_hold_done = 1'b1;
    end else if (out_gap > 0) begin
      out_ready_i <= 1'b0;
      out_gap--;
    end else begin
      out_ready_i <= 1'b1;
      if (!calm && $urandom_range(0, 15) == 0) out_gap = $urandom_range(1, 12);
    end
  end

  task automatic write_target(input logic [CFG_IDX_W-1:0] idx, input logic [STOCK_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_targets(input logic [STOCK_W-1:0] t200, input logic [STOCK_W-1:0] t100,
                             input logic [STOCK_W-1:0] t50);
    write_target(CFG_TGT_200, t200);
    write_target(CFG_TGT_100, t100);
    write_target(CFG_TGT_50, t50);
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (pending_amounts.size() != 0 || in_valid_i || payouts_due.size() != 0)
      @(posedge clk_i);
  endtask

  // Mostly payable amounts, weighted to small ones so the stock lasts, with some
  // zero, odd and full-range values mixed in.
  function automatic logic [AMT_W-1:0] pick_amount();
    logic [AMT_W-1:0] amt;
    int               sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) amt = AMT_W'($urandom_range(0, 12) * COIN_50);
    else if (sel < 60) amt = '0;
    else if (sel < 75) amt = AMT_W'($urandom_range(0, 46) * COIN_50);
    else if (sel < 85) amt = AMT_W'($urandom_range(0, 16'hFFFF));
    else amt = AMT_W'($urandom_range(0, 2300));
    return amt;
  endfunction

  task automatic run_phase(input int count);
    @(posedge clk_i);
    repeat (count) pending_amounts.push_back(pick_amount());
    wait_drained();
  endtask

  initial begin
    logic [AMT_W-1:0] directed[$];
    directed = '{16'd0, 16'hFFFF, 16'h8000, 16'd1, 16'd25, 16'd49, 16'd50, 16'd100,
                 16'd150, 16'd200, 16'd250, 16'd0, 16'd2250, 16'd2200, 16'd350,
                 16'h7FFF, 16'd0};
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // An index past the three targets must leave every level alone.
    write_target(CFG_UNUSED, 8'hA5);
    @(posedge clk_i);
    foreach (directed[i]) pending_amounts.push_back(directed[i]);
    wait_drained();

    set_targets(8'd0, 8'd0, 8'd0);
    run_phase(PHASE_ITEMS);
    set_targets(8'hFF, 8'hFF, 8'hFF);
    run_phase(PHASE_ITEMS);
    set_targets(STOCK_W'($urandom_range(0, 255)), STOCK_W'($urandom_range(0, 255)),
                STOCK_W'($urandom_range(0, 255)));
    run_phase(PHASE_ITEMS);
    set_targets(8'd0, 8'hFF, STOCK_W'($urandom_range(0, 255)));
    run_phase(PHASE_ITEMS);
    set_targets(STOCK_W'($urandom_range(0, 255)), STOCK_W'($urandom_range(0, 255)),
                STOCK_W'($urandom_range(0, 255)));
    run_phase(PHASE_ITEMS);
    // The stock is never refilled, so by now most amounts are zero or unpayable.
    set_targets(8'hFF, 8'd0, 8'hFF);
    calm = 1'b1;
    run_phase(PHASE_ITEMS);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (payouts_due.size() != 0) begin
      $error("%0d predicted results never arrived", payouts_due.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/csel_pkg.sv
rtl/core/csel_dp.sv
rtl/core/csel_ctrl.sv
rtl/core/coin_change_selector_unit.sv
sim/coin_change_selector_unit_tb.sv
